### src/base64_block_decoder_defines.svh
// assertion helpers for the base64 block decoder
`ifndef BASE64_BLOCK_DECODER_DEFINES_SVH
`define BASE64_BLOCK_DECODER_DEFINES_SVH

// condition implies check in the same cycle
`define B64D_ASSERT_NOW(label, cond, check) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error("b64d assertion failed");

// condition implies check in the next cycle
`define B64D_ASSERT_NEXT(label, cond, check) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error("b64d assertion failed");

`endif

### src/b64d_pkg.sv
`default_nettype none
package b64d_pkg;

  localparam int COUNT_BITS  = 32;
  localparam int OFFSET_BITS = 36;
  localparam int LANES       = 4;
  localparam int LANE_CHARS  = 4;
  localparam int POS_BITS    = $clog2(LANE_CHARS);
  localparam int LANE_BITS   = $clog2(LANES);

  typedef struct packed {
    logic [63:0] chars_low;
    logic [63:0] chars_high;
    logic        last_block;
  } text_t;

  typedef struct packed {
    logic [63:0]            bytes_low;
    logic [31:0]            bytes_high;
    logic                   bad_input;
    logic [OFFSET_BITS-1:0] bad_offset;
    logic [7:0]             bad_char;
    logic                   stream_end;
  } data_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // what one lane reports for its group of four characters
  typedef struct packed {
    logic [23:0]         bytes;
    logic                bad;
    logic [POS_BITS-1:0] pos;
    logic [7:0]          chr;
  } lane_res_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.ok  = 1'b1;
    s.val = '0;
    if (c inside {[8'h41:8'h5a]}) begin
      s.val = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7a]}) begin
      s.val = 6'(c - 8'h47);
    end else if (c inside {[8'h30:8'h39]}) begin
      s.val = 6'(c + 8'h04);
    end else if (c == 8'h2b) begin
      s.val = 6'd62;
    end else if (c == 8'h2f) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### src/base64_block_decoder.sv
// an accepted request is registered in the lane stage, then in the merge stage, whose register holds the result
// throughput: one block of 16 characters per cycle while the output is not stalled; four lanes decode in parallel
// a stalled output holds its result while one more request waits in the lane stage
// reset clears both valid flags and the block counter; data registers are not reset
`default_nettype none
`include "base64_block_decoder_defines.svh"
module base64_block_decoder import b64d_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  text_valid,
  output logic  text_ready,
  input  text_t text,
  output logic  data_valid,
  input  logic  data_ready,
  output data_t data
);

  logic [127:0]          all_chars;
  lane_res_t [LANES-1:0] lane_out;
  lane_res_t [LANES-1:0] s1_lanes;
  logic [COUNT_BITS-1:0] s1_count;
  logic                  s1_last;
  logic                  s1_valid;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  data_t                 merged;
  logic                  out_load;
  logic                  text_take;

  assign all_chars  = {text.chars_high, text.chars_low};
  assign out_load   = !data_valid || data_ready;
  assign text_ready = !s1_valid || out_load;
  assign text_take  = text_valid && text_ready;
  assign count_next = text.last_block ? '0 : count + 1'b1;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    b64d_lane u_lane (
      .chars (all_chars[8*LANE_CHARS*g +: 8*LANE_CHARS]),
      .res   (lane_out[g])
    );
  end

  b64d_merge u_merge (
    .lanes      (s1_lanes),
    .count      (s1_count),
    .last_block (s1_last),
    .result     (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      data_valid <= 1'b0;
      count      <= '0;
    end else begin
      if (text_ready) s1_valid <= text_valid;
      if (out_load) data_valid <= s1_valid;
      if (text_take) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (text_take) begin
      s1_lanes <= lane_out;
      s1_count <= count;
      s1_last  <= text.last_block;
    end
    if (out_load && s1_valid) data <= merged;
  end

  `B64D_ASSERT_NEXT(a_count_clear, text_take && text.last_block, count == '0)
  `B64D_ASSERT_NOW(a_clean_no_err, data_valid && !data.bad_input,
                   data.bad_offset == '0 && data.bad_char == '0)
  `B64D_ASSERT_NOW(a_bad_no_bytes, data_valid && data.bad_input,
                   data.bytes_low == '0 && data.bytes_high == '0)
  `B64D_ASSERT_NEXT(a_s1_held, s1_valid && !out_load, s1_valid)

endmodule
`default_nettype wire

### src/b64d_lane.sv
`default_nettype none
module b64d_lane import b64d_pkg::*; (
  input  logic [8*LANE_CHARS-1:0] chars,
  output lane_res_t               res
);

  sextet_t s [LANE_CHARS];
  logic [23:0] word;

  always_comb begin
    for (int i = 0; i < LANE_CHARS; i++) begin
      s[i] = sextet_of(chars[8*i +: 8]);
    end
    word = {s[0].val, s[1].val, s[2].val, s[3].val};
    // byte order of the stream: high byte of the group first
    res.bytes = {word[7:0], word[15:8], word[23:16]};
    res.bad   = 1'b0;
    res.pos   = '0;
    res.chr   = '0;
    // scan downward so the lowest bad character wins
    for (int i = LANE_CHARS - 1; i >= 0; i--) begin
      if (!s[i].ok) begin
        res.bad = 1'b1;
        res.pos = POS_BITS'(i);
        res.chr = chars[8*i +: 8];
      end
    end
  end

endmodule
`default_nettype wire

### src/b64d_merge.sv
`default_nettype none
module b64d_merge import b64d_pkg::*; (
  input  lane_res_t [LANES-1:0] lanes,
  input  logic [COUNT_BITS-1:0] count,
  input  logic                  last_block,
  output data_t                 result
);

  logic                          any_bad;
  logic [LANE_BITS-1:0]          sel;
  logic [8*3*LANES-1:0]          all_bytes;
  logic [COUNT_BITS+LANE_BITS+POS_BITS-1:0] full_offset;

  always_comb begin
    any_bad = 1'b0;
    sel     = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (lanes[i].bad) begin
        any_bad = 1'b1;
        sel     = LANE_BITS'(i);
      end
    end
    for (int i = 0; i < LANES; i++) begin
      all_bytes[24*i +: 24] = lanes[i].bytes;
    end
    full_offset = {count, sel, lanes[sel].pos};

    result.bytes_low  = any_bad ? '0 : all_bytes[63:0];
    result.bytes_high = any_bad ? '0 : all_bytes[95:64];
    result.bad_input  = any_bad;
    result.bad_offset = any_bad ? OFFSET_BITS'(full_offset) : '0;
    result.bad_char   = any_bad ? lanes[sel].chr : '0;
    result.stream_end = last_block;
  end

endmodule
`default_nettype wire
